### rtl/core/dltq_pkg.sv
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants for the delta list timer queue: request and
// result payloads, the slot record that moves along the cell chain, and the
// per-cell command structs.
// ----------------------------------------------------------------------------
package dltq_pkg;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  // register map (byte addresses)
  localparam int unsigned PADDR_W        = 3;
  localparam logic [2:0]  ADDR_TICK_STEP = 3'h0;

  localparam int unsigned TAG_W   = 8;
  localparam int unsigned ID_W    = 3;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned STEP_W  = 16;

  // input request payload
  typedef struct packed {
    logic               cmd;
    logic [TAG_W-1:0]   task_tag;
    logic [DELAY_W-1:0] start_delay;
    logic [DELAY_W-1:0] repeat_period;
  } dltq_in_t;

  // result payload
  typedef struct packed {
    logic [3:0]       assigned_id;
    logic             head_ready;
    logic [ID_W-1:0]  head_id;
    logic [TAG_W-1:0] head_tag;
  } dltq_out_t;

  // one task slot
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
    logic               flag;
  } dltq_slot_t;

  // add request broadcast to every cell during a walk
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [DELAY_W-1:0] want;
    logic [DELAY_W-1:0] period;
    logic [ID_W-1:0]    new_id;
  } dltq_add_t;

  // tick command for a cell
  typedef struct packed {
    logic              tick;
    logic [STEP_W-1:0] step;
  } dltq_tick_t;

endpackage

### rtl/core/delta_list_timer_queue_core.sv
// ----------------------------------------------------------------------------
// delta_list_timer_queue_core
// Timer queue kept as a delta list in a chain of slot cells. An add request
// sends a running-sum wavefront down the chain, one cell per cycle, and
// inserts the task where it lands; a tick counts down the head slot.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+-------------------
//   request   | in        | in_valid_i / in_stall_o   | in_req_i  (dltq_in_t)
//   result    | out       | out_valid_o / out_stall_i | out_res_o (dltq_out_t)
//   config    | in        | APB psel/penable/pready   | tick_step @ 0x0
//
// One request is processed at a time; the next one is taken once the result
// of the previous one sits in the output register. A tick or an add to a full
// queue goes from idle straight to the response state; any other add walks
// the wavefront down the chain, one cell per cycle, until it lands in a slot.
// Reset clears all slots to empty with ids SLOTS-1 down to 0 and tick_step
// to 1. A stalled result holds the next request in the response state until
// the result is taken.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core
  import dltq_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dltq_in_t           in_req_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dltq_out_t          out_res_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned SUM_W   = DELAY_W + $clog2(SLOTS) + 1;
  localparam logic [31:0] SLOTS_W = 32'(SLOTS);
  localparam logic [3:0]  ID_FULL = SLOTS_W[3:0];

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [STEP_W-1:0] tick_step_q;
  dltq_add_t         add_q;
  logic [3:0]        res_id_q, res_id_d;
  logic              out_valid_q;
  dltq_out_t         out_res_q;

  logic in_accept;
  logic full;
  logic start;
  logic walk_done;
  logic out_free;

  dltq_slot_t       slot_rec  [SLOTS];
  dltq_slot_t       right_rec [SLOTS];
  logic [SUM_W-1:0] right_sum [SLOTS];
  logic [SLOTS-1:0] right_wave;
  logic [SLOTS-1:0] shift_vec;
  logic [SLOTS-1:0] hit_vec;
  logic [SLOTS-1:0] wave_vec;
  dltq_tick_t       head_tick;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_step_q <= STEP_W'(1);
    end else if (psel && penable && pwrite && (paddr == ADDR_TICK_STEP)) begin
      tick_step_q <= pwdata[STEP_W-1:0];
    end
  end

  always_comb begin
    if (paddr == ADDR_TICK_STEP) begin
      prdata = {{(32-STEP_W){1'b0}}, tick_step_q};
    end else begin
      prdata = '0;
    end
  end

  // request decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (slot_rec[SLOTS-1].tag != '0);
  assign start      = in_accept && (in_req_i.cmd == CMD_ADD) && !full;
  assign walk_done  = (|hit_vec) || right_wave[SLOTS-1];
  assign out_free   = !out_valid_q || !out_stall_i;

  assign head_tick.tick = in_accept && (in_req_i.cmd == CMD_TICK);
  assign head_tick.step = tick_step_q;

  // latched add request
  always_ff @(posedge clk_i) begin
    if (start) begin
      add_q.tag    <= in_req_i.task_tag;
      add_q.want   <= in_req_i.start_delay;
      add_q.period <= in_req_i.repeat_period;
      add_q.new_id <= slot_rec[SLOTS-1].id;
    end
  end

  // slot chain
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    dltq_slot_t       left_rec;
    logic             left_wave;
    logic [SUM_W-1:0] left_sum;
    logic             left_shift;
    dltq_tick_t       cell_tick;

    if (k == 0) begin : g_head
      assign left_rec   = '0;
      assign left_wave  = start;
      assign left_sum   = '0;
      assign left_shift = 1'b0;
      assign cell_tick  = head_tick;
    end else begin : g_body
      assign left_rec   = right_rec[k-1];
      assign left_wave  = right_wave[k-1];
      assign left_sum   = right_sum[k-1];
      assign left_shift = shift_vec[k-1];
      assign cell_tick  = '0;
    end

    dltq_cell #(
      .SUM_W  (SUM_W),
      .RST_ID (ID_W'(SLOTS - 1 - k))
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .left_i       (left_rec),
      .left_wave_i  (left_wave),
      .left_sum_i   (left_sum),
      .shift_i      (left_shift),
      .add_i        (add_q),
      .tick_i       (cell_tick),
      .slot_o       (slot_rec[k]),
      .right_o      (right_rec[k]),
      .right_wave_o (right_wave[k]),
      .right_sum_o  (right_sum[k]),
      .shift_o      (shift_vec[k]),
      .hit_o        (hit_vec[k]),
      .wave_o       (wave_vec[k])
    );
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    res_id_d = res_id_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_id_d = ID_FULL;
          state_d  = start ? ST_WALK : ST_RESP;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          res_id_d = (|hit_vec) ? {1'b0, add_q.new_id} : ID_FULL;
          state_d  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_id_q <= res_id_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_RESP) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RESP) && out_free) begin
      out_res_q.assigned_id <= res_id_q;
      out_res_q.head_ready  <= slot_rec[0].flag;
      out_res_q.head_id     <= slot_rec[0].id;
      out_res_q.head_tag    <= slot_rec[0].tag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // the wavefront sits in at most one cell
  a_wave_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wave_vec))
    else $error("walk wavefront in more than one cell");

  // a task lands in at most one cell
  a_hit_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("task inserted in more than one cell");

  // the wavefront only moves while walking
  a_wave_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|wave_vec) |-> (state_q == ST_WALK))
    else $error("wavefront outside a walk");

  // a walk keeps going until it lands
  a_walk_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WALK) && !walk_done) |=> (state_q == ST_WALK))
    else $error("walk left before landing");

  // an add to a full queue starts no walk
  a_full_nowalk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_req_i.cmd == CMD_ADD) && full) |=> (state_q == ST_RESP))
    else $error("walk started on a full queue");

endmodule

### rtl/core/dltq_cell.sv
// ----------------------------------------------------------------------------
// dltq_cell
// One slot of the delta list. Holds the slot record and the walk wavefront
// register; adds its delay to the running sum, decides whether the new task
// goes here, and shifts in its left neighbor's record when a task is
// inserted further up the chain.
// ----------------------------------------------------------------------------
module dltq_cell
  import dltq_pkg::*;
#(
  parameter int unsigned     SUM_W  = 36,
  parameter logic [ID_W-1:0] RST_ID = '0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dltq_slot_t       left_i,
  input  logic             left_wave_i,
  input  logic [SUM_W-1:0] left_sum_i,
  input  logic             shift_i,
  input  dltq_add_t        add_i,
  input  dltq_tick_t       tick_i,
  output dltq_slot_t       slot_o,
  output dltq_slot_t       right_o,
  output logic             right_wave_o,
  output logic [SUM_W-1:0] right_sum_o,
  output logic             shift_o,
  output logic             hit_o,
  output logic             wave_o
);

  dltq_slot_t       slot_q, slot_d;
  logic             wave_q;
  logic [SUM_W-1:0] sum_q;

  logic [SUM_W-1:0]   sum_new;
  logic [SUM_W-1:0]   want_w;
  logic [SUM_W-1:0]   sum_diff;
  logic [DELAY_W-1:0] rem;
  logic [DELAY_W-1:0] new_delay;
  logic [DELAY_W-1:0] tick_delay;
  logic               split;
  logic               hit;

  // running sum and insertion decision
  always_comb begin
    sum_new  = sum_q + SUM_W'(slot_q.delay);
    want_w   = SUM_W'(add_i.want);
    split    = sum_new > want_w;
    hit      = wave_q & (split | (slot_q.tag == '0));
    sum_diff = sum_new - want_w;
    rem      = sum_diff[DELAY_W-1:0];
    if (split) begin
      new_delay = add_i.want - sum_q[DELAY_W-1:0];
    end else begin
      new_delay = add_i.want - sum_new[DELAY_W-1:0];
    end
  end

  // clamped countdown of this slot on a tick
  always_comb begin
    if (slot_q.delay > DELAY_W'(tick_i.step)) begin
      tick_delay = slot_q.delay - DELAY_W'(tick_i.step);
    end else begin
      tick_delay = '0;
    end
  end

  // record handed right: carries the split remainder when the task lands here
  always_comb begin
    right_o = slot_q;
    if (hit && split) begin
      right_o.delay = rem;
      right_o.flag  = slot_q.flag | (rem == '0);
    end
  end

  // next slot contents
  always_comb begin
    slot_d = slot_q;
    if (tick_i.tick && (slot_q.tag != '0)) begin
      slot_d.delay = tick_delay;
      slot_d.flag  = slot_q.flag | (tick_delay == '0);
    end else if (hit) begin
      slot_d.tag    = add_i.tag;
      slot_d.id     = add_i.new_id;
      slot_d.delay  = new_delay;
      slot_d.period = add_i.period;
      slot_d.flag   = (new_delay == '0);
    end else if (shift_i) begin
      slot_d = left_i;
    end
  end

  // slot storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '{tag: '0, id: RST_ID, delay: '0, period: '0, flag: 1'b0};
    end else begin
      slot_q <= slot_d;
    end
  end

  // wavefront flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= 1'b0;
    end else begin
      wave_q <= left_wave_i;
    end
  end

  // running sum carried with the wavefront
  always_ff @(posedge clk_i) begin
    sum_q <= left_sum_i;
  end

  assign slot_o       = slot_q;
  assign right_wave_o = wave_q & ~hit;
  assign right_sum_o  = sum_new;
  assign shift_o      = shift_i | hit;
  assign hit_o        = hit;
  assign wave_o       = wave_q;

endmodule
